// ----- hw/rtl/tsl_pkg.sv -----
// tsl_pkg: shared constants, mode and register codes, and the alignment struct
// for the tiled surface level layout block; no dependencies
package tsl_pkg;

  localparam int EXTENT_BITS = 15;
  localparam int EXT_W       = EXTENT_BITS + 1;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_1D     = 2'd1;
  localparam logic [1:0] MODE_2D     = 2'd2;

  localparam logic [1:0] CFG_GROUP_BYTES = 2'd0;
  localparam logic [1:0] CFG_PIPES       = 2'd1;
  localparam logic [1:0] CFG_BANKS       = 2'd2;

  localparam logic [3:0] GROUP_LOG2_MIN = 4'd8;
  localparam logic [3:0] GROUP_LOG2_MAX = 4'd12;
  localparam logic [1:0] BANKS_LOG2_MIN = 2'd2;
  localparam logic [2:0] ESZ_LOG2_MAX   = 3'd4;

  localparam logic [3:0] TILE_EDGE_LOG2        = 4'd3;
  localparam logic [3:0] LINEAR_MIN_PITCH_LOG2 = 4'd6;
  localparam logic [3:0] SCANOUT_1B_LOG2       = 4'd6;
  localparam logic [3:0] SCANOUT_WIDE_LOG2     = 4'd5;
  localparam logic [4:0] MIN_BASE_ALIGN_LOG2   = 5'd8;
  localparam logic [4:0] BASE_FACTOR_LOG2      = 5'd6;

  typedef struct packed {
    logic [3:0] pa_log2;
    logic [2:0] ha_log2;
    logic [4:0] ba_log2;
    logic [2:0] bs_log2;
  } tsl_align_t;

endpackage

// ----- hw/rtl/tsl_extent.sv -----
// tsl_extent: mip level extent, max(1, base >> level), power-of-two rounded
// above level zero; depends on tsl_pkg
module tsl_extent import tsl_pkg::*; (
  input  logic [EXTENT_BITS-1:0] base,
  input  logic [3:0]             level,
  output logic [EXT_W-1:0]       extent
);

  logic [EXT_W-1:0] shifted;
  logic [EXT_W-1:0] clamped;
  logic [EXT_W-1:0] smear;

  always_comb begin
    shifted = {1'b0, base} >> level;
    clamped = (shifted == '0) ? EXT_W'(1) : shifted;
    smear   = clamped - EXT_W'(1);
    for (int i = 0; i < $clog2(EXT_W); i++) begin
      smear = smear | (smear >> (1 << i));
    end
    extent = (level != 4'd0) ? (smear + EXT_W'(1)) : clamped;
  end

endmodule

// ----- hw/rtl/tsl_align.sv -----
// tsl_align: pitch, height and base alignment exponents for the tiling mode
// depends on tsl_pkg
module tsl_align import tsl_pkg::*; (
  input  logic [1:0] tiling_mode,
  input  logic [2:0] element_size_log2,
  input  logic [1:0] samples_log2,
  input  logic       scanout_en,
  input  logic [3:0] group_bytes_log2,
  input  logic [1:0] pipes_log2,
  input  logic [1:0] banks_log2,
  output tsl_align_t align
);

  logic [3:0] g;
  logic [1:0] kl;
  logic [2:0] esz;
  logic [3:0] s;
  logic [3:0] e1d;
  logic [3:0] epa;
  logic [3:0] scan_min;
  logic [4:0] ba_a;
  logic [4:0] ba_b;

  always_comb begin
    if (group_bytes_log2 < GROUP_LOG2_MIN) begin
      g = GROUP_LOG2_MIN;
    end else if (group_bytes_log2 > GROUP_LOG2_MAX) begin
      g = GROUP_LOG2_MAX;
    end else begin
      g = group_bytes_log2;
    end
    kl  = (banks_log2 < BANKS_LOG2_MIN) ? BANKS_LOG2_MIN : banks_log2;
    esz = (element_size_log2 > ESZ_LOG2_MAX) ? ESZ_LOG2_MAX : element_size_log2;
    s   = TILE_EDGE_LOG2 + 4'(esz) + 4'(samples_log2);
    // max(8, group >> s) as an exponent
    e1d = (g >= 4'(s + TILE_EDGE_LOG2)) ? 4'(g - s) : TILE_EDGE_LOG2;
    scan_min = (esz == 3'd0) ? SCANOUT_1B_LOG2 : SCANOUT_WIDE_LOG2;
    ba_a = 5'(kl) + BASE_FACTOR_LOG2;
    ba_b = '0;

    align.bs_log2 = esz + 3'(samples_log2);
    case (tiling_mode)
      MODE_1D: begin
        epa           = e1d;
        align.ha_log2 = 3'(TILE_EDGE_LOG2);
      end
      MODE_2D: begin
        epa           = e1d + 4'(kl);
        align.ha_log2 = 3'(TILE_EDGE_LOG2) + 3'(pipes_log2);
      end
      default: begin
        epa           = (4'(g - 4'(esz)) > LINEAR_MIN_PITCH_LOG2) ?
                        4'(g - 4'(esz)) : LINEAR_MIN_PITCH_LOG2;
        align.ha_log2 = 3'd0;
      end
    endcase
    if ((tiling_mode == MODE_1D || tiling_mode == MODE_2D) && scanout_en &&
        (scan_min > epa)) begin
      epa = scan_min;
    end
    align.pa_log2 = epa;

    if (tiling_mode == MODE_2D) begin
      // max(pipes*banks*S*B*64, pitch*height*S*B)
      ba_b = 5'(epa) + 5'(TILE_EDGE_LOG2);
      align.ba_log2 = 5'(pipes_log2) + 5'(align.bs_log2) +
                      ((ba_a > ba_b) ? ba_a : ba_b);
    end else begin
      align.ba_log2 = (5'(g) > MIN_BASE_ALIGN_LOG2) ? 5'(g) : MIN_BASE_ALIGN_LOG2;
    end
  end

endmodule

// ----- hw/rtl/tiled_surface_level_layout_core.sv -----
// tiled_surface_level_layout_core: top level with config registers, input
// register, layout arithmetic and result register
// depends on tsl_pkg, tsl_align, tsl_extent
// start passes the input register, then the result register, to out_valid;
// one request per cycle; busy is always low and the receiver cannot stall
// synchronous active-low reset clears the valid bits and loads the config
// registers with group 256 bytes, 2 pipes, 4 banks
module tiled_surface_level_layout_core import tsl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_wdata,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_tiling_mode,
  input  logic [EXTENT_BITS-1:0] in_base_width,
  input  logic [EXTENT_BITS-1:0] in_base_height,
  input  logic [3:0]             in_mip_level,
  input  logic [2:0]             in_element_size_log2,
  input  logic [1:0]             in_samples_log2,
  input  logic                   in_scanout_en,
  input  logic                   in_degrade_check,
  output logic                   out_valid,
  output logic [12:0]            out_pitch_align,
  output logic [6:0]             out_height_align,
  output logic [31:0]            out_base_align_bytes,
  output logic [15:0]            out_aligned_pitch,
  output logic [15:0]            out_aligned_height,
  output logic [31:0]            out_row_bytes,
  output logic [39:0]            out_plane_bytes,
  output logic                   out_degrades
);

  logic [3:0] group_r;
  logic [1:0] pipes_r;
  logic [1:0] banks_r;

  logic                   valid_r;
  logic [1:0]             mode_r;
  logic [EXTENT_BITS-1:0] bw_r;
  logic [EXTENT_BITS-1:0] bh_r;
  logic [3:0]             level_r;
  logic [2:0]             esz_r;
  logic [1:0]             sl_r;
  logic                   scan_r;
  logic                   check_r;

  tsl_align_t       align;
  logic [EXT_W-1:0] w;
  logic [EXT_W-1:0] h;
  logic [16:0]      pa_m1;
  logic [15:0]      ha_m1;
  logic [16:0]      ap;
  logic [15:0]      ah;
  logic [23:0]      pb;
  logic [31:0]      area;
  logic [39:0]      sb;
  logic             deg;

  logic        out_valid_r;
  logic [12:0] pa_r;
  logic [6:0]  ha_r;
  logic [31:0] ba_r;
  logic [15:0] ap_r;
  logic [15:0] ah_r;
  logic [31:0] pb_r;
  logic [39:0] sb_r;
  logic        deg_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= GROUP_LOG2_MIN;
      pipes_r <= 2'd1;
      banks_r <= BANKS_LOG2_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GROUP_BYTES: group_r <= cfg_wdata;
        CFG_PIPES:       pipes_r <= cfg_wdata[1:0];
        CFG_BANKS:       banks_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= start && !busy;
    end
    mode_r  <= in_tiling_mode;
    bw_r    <= in_base_width;
    bh_r    <= in_base_height;
    level_r <= in_mip_level;
    esz_r   <= in_element_size_log2;
    sl_r    <= in_samples_log2;
    scan_r  <= in_scanout_en;
    check_r <= in_degrade_check;
  end

  tsl_align u_align (
    .tiling_mode       (mode_r),
    .element_size_log2 (esz_r),
    .samples_log2      (sl_r),
    .scanout_en        (scan_r),
    .group_bytes_log2  (group_r),
    .pipes_log2        (pipes_r),
    .banks_log2        (banks_r),
    .align             (align)
  );

  tsl_extent u_width (
    .base   (bw_r),
    .level  (level_r),
    .extent (w)
  );

  tsl_extent u_height (
    .base   (bh_r),
    .level  (level_r),
    .extent (h)
  );

  always_comb begin
    pa_m1 = (17'(1) << align.pa_log2) - 17'(1);
    ha_m1 = (16'(1) << align.ha_log2) - 16'(1);
    deg   = check_r && ((17'(w) <= pa_m1) || (16'(h) <= ha_m1));
    ap    = (17'(w) + pa_m1) & ~pa_m1;
    ah    = (16'(h) + ha_m1) & ~ha_m1;
    pb    = 24'(ap) << align.bs_log2;
    // aligned pitch never exceeds 32768, so a 16 by 16 product suffices
    area  = 32'(ap[15:0]) * 32'(ah);
    sb    = 40'(area) << align.bs_log2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_r;
    end
    pa_r  <= 13'(1) << align.pa_log2;
    ha_r  <= 7'(1) << align.ha_log2;
    ba_r  <= 32'(1) << align.ba_log2;
    deg_r <= deg;
    ap_r  <= deg ? 16'd0 : ap[15:0];
    ah_r  <= deg ? 16'd0 : ah;
    pb_r  <= deg ? 32'd0 : 32'(pb);
    sb_r  <= deg ? 40'd0 : sb;
  end

  assign out_valid            = out_valid_r;
  assign out_pitch_align      = pa_r;
  assign out_height_align     = ha_r;
  assign out_base_align_bytes = ba_r;
  assign out_aligned_pitch    = ap_r;
  assign out_aligned_height   = ah_r;
  assign out_row_bytes        = pb_r;
  assign out_plane_bytes      = sb_r;
  assign out_degrades         = deg_r;

endmodule

// ----- tb/tsl_checker.sv -----
// tsl_checker: watches the request and result ports of the tiled surface level
// layout core, predicts each layout and compares it field by field
// depends on tsl_pkg
module tsl_checker import tsl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_wdata,
  input  logic                   start,
  input  logic                   busy,
  input  logic [1:0]             in_tiling_mode,
  input  logic [EXTENT_BITS-1:0] in_base_width,
  input  logic [EXTENT_BITS-1:0] in_base_height,
  input  logic [3:0]             in_mip_level,
  input  logic [2:0]             in_element_size_log2,
  input  logic [1:0]             in_samples_log2,
  input  logic                   in_scanout_en,
  input  logic                   in_degrade_check,
  input  logic                   out_valid,
  input  logic [12:0]            out_pitch_align,
  input  logic [6:0]             out_height_align,
  input  logic [31:0]            out_base_align_bytes,
  input  logic [15:0]            out_aligned_pitch,
  input  logic [15:0]            out_aligned_height,
  input  logic [31:0]            out_row_bytes,
  input  logic [39:0]            out_plane_bytes,
  input  logic                   out_degrades,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [12:0] pa;
    logic [6:0]  ha;
    logic [31:0] ba;
    logic [15:0] ap;
    logic [15:0] ah;
    logic [31:0] pb;
    logic [39:0] sb;
    logic        deg;
  } layout_t;

  logic [3:0] group_log2_q = 4'd8;
  logic [1:0] pipes_log2_q = 2'd1;
  logic [1:0] banks_log2_q = 2'd2;
  layout_t    expected_layouts[$];
  layout_t    want;
  int         mismatches = 0;

  function automatic longint unsigned max64(input longint unsigned a, input longint unsigned b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint unsigned level_extent(input logic [EXTENT_BITS-1:0] base,
                                                   input logic [3:0] lvl);
    longint unsigned e;
    longint unsigned p;
    e = longint'(base) >> lvl;
    if (e == 0) e = 1;
    if (lvl == 0) return e;
    p = 1;
    while (p < e) p = p << 1;
    return p;
  endfunction

  function automatic layout_t predict_layout(
    input logic [1:0]             mode,
    input logic [EXTENT_BITS-1:0] bw,
    input logic [EXTENT_BITS-1:0] bh,
    input logic [3:0]             lvl,
    input logic [2:0]             esz_in,
    input logic [1:0]             sl,
    input logic                   scan,
    input logic                   check
  );
    layout_t r;
    longint unsigned g, kl, esz, grp, bpe, samp, pipes, banks, tile;
    longint unsigned pa, ha, ba, w, h, ap, ah, pb, sb;
    logic deg;
    g = 64'(group_log2_q);
    if (g < 64'(GROUP_LOG2_MIN)) g = 64'(GROUP_LOG2_MIN);
    if (g > 64'(GROUP_LOG2_MAX)) g = 64'(GROUP_LOG2_MAX);
    kl = (banks_log2_q < BANKS_LOG2_MIN) ? 64'(BANKS_LOG2_MIN) : 64'(banks_log2_q);
    esz = (esz_in > ESZ_LOG2_MAX) ? 64'(ESZ_LOG2_MAX) : 64'(esz_in);
    grp = 64'd1 << g;
    bpe = 64'd1 << esz;
    samp = 64'd1 << sl;
    pipes = 64'd1 << pipes_log2_q;
    banks = 64'd1 << kl;
    tile = 64'd1 << TILE_EDGE_LOG2;
    case (mode)
      MODE_1D: begin
        pa = max64(tile, grp >> (64'(TILE_EDGE_LOG2) + esz + 64'(sl)));
        ha = tile;
        ba = max64(64'd1 << MIN_BASE_ALIGN_LOG2, grp);
      end
      MODE_2D: begin
        pa = max64(tile * banks, (grp * banks) >> (64'(TILE_EDGE_LOG2) + esz + 64'(sl)));
        ha = tile * pipes;
        ba = 0;
      end
      default: begin
        pa = max64(64'd1 << LINEAR_MIN_PITCH_LOG2, grp >> esz);
        ha = 1;
        ba = max64(64'd1 << MIN_BASE_ALIGN_LOG2, grp);
      end
    endcase
    if ((mode == MODE_1D || mode == MODE_2D) && scan) begin
      pa = max64((esz == 0) ? (64'd1 << SCANOUT_1B_LOG2) : (64'd1 << SCANOUT_WIDE_LOG2), pa);
    end
    if (mode == MODE_2D) begin
      ba = max64((pipes * banks * samp * bpe) << BASE_FACTOR_LOG2, pa * ha * samp * bpe);
    end
    w = level_extent(bw, lvl);
    h = level_extent(bh, lvl);
    ap = 0;
    ah = 0;
    pb = 0;
    sb = 0;
    deg = 1'b0;
    if (check && (w < pa || h < ha)) begin
      deg = 1'b1;
    end else begin
      ap = (w + pa - 1) & ~(pa - 1);
      ah = (h + ha - 1) & ~(ha - 1);
      pb = ap * bpe * samp;
      sb = pb * ah;
    end
    r.pa = pa[12:0];
    r.ha = ha[6:0];
    r.ba = ba[31:0];
    r.ap = ap[15:0];
    r.ah = ah[15:0];
    r.pb = pb[31:0];
    r.sb = sb[39:0];
    r.deg = deg;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      group_log2_q <= 4'd8;
      pipes_log2_q <= 2'd1;
      banks_log2_q <= 2'd2;
      expected_layouts.delete();
    end else begin
      if (out_valid) begin
        if (expected_layouts.size() == 0) begin
          $error("result with no request waiting");
          mismatches++;
        end else begin
          want = expected_layouts.pop_front();
          if (want.pa !== out_pitch_align) begin
            $error("pitch_align: expected %0d, actual %0d", want.pa, out_pitch_align);
            mismatches++;
          end
          if (want.ha !== out_height_align) begin
            $error("height_align: expected %0d, actual %0d", want.ha, out_height_align);
            mismatches++;
          end
          if (want.ba !== out_base_align_bytes) begin
            $error("base_align_bytes: expected %0d, actual %0d", want.ba,
                   out_base_align_bytes);
            mismatches++;
          end
          if (want.ap !== out_aligned_pitch) begin
            $error("aligned_pitch: expected %0d, actual %0d", want.ap, out_aligned_pitch);
            mismatches++;
          end
          if (want.ah !== out_aligned_height) begin
            $error("aligned_height: expected %0d, actual %0d", want.ah, out_aligned_height);
            mismatches++;
          end
          if (want.pb !== out_row_bytes) begin
            $error("row_bytes: expected %0d, actual %0d", want.pb, out_row_bytes);
            mismatches++;
          end
          if (want.sb !== out_plane_bytes) begin
            $error("plane_bytes: expected %0d, actual %0d", want.sb, out_plane_bytes);
            mismatches++;
          end
          if (want.deg !== out_degrades) begin
            $error("degrades: expected %0d, actual %0d", want.deg, out_degrades);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_layouts.push_back(predict_layout(in_tiling_mode, in_base_width,
          in_base_height, in_mip_level, in_element_size_log2, in_samples_log2,
          in_scanout_en, in_degrade_check));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROUP_BYTES: group_log2_q <= cfg_wdata;
          CFG_PIPES:       pipes_log2_q <= cfg_wdata[1:0];
          CFG_BANKS:       banks_log2_q <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending <= expected_layouts.size();
  end

endmodule

// ----- tb/tb.sv -----
// tb: drives layout requests and register writes into the tiled surface level
// layout core and gives the verdict; depends on tsl_pkg, tiled_surface_level_layout_core and tsl_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsl_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 80;

  typedef struct {
    logic [1:0]             mode;
    logic [EXTENT_BITS-1:0] bw;
    logic [EXTENT_BITS-1:0] bh;
    logic [3:0]             lvl;
    logic [2:0]             esz;
    logic [1:0]             sl;
    logic                   scan;
    logic                   check;
  } layout_req_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [1:0]             cfg_index;
  logic [3:0]             cfg_wdata;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_tiling_mode;
  logic [EXTENT_BITS-1:0] in_base_width;
  logic [EXTENT_BITS-1:0] in_base_height;
  logic [3:0]             in_mip_level;
  logic [2:0]             in_element_size_log2;
  logic [1:0]             in_samples_log2;
  logic                   in_scanout_en;
  logic                   in_degrade_check;
  logic                   out_valid;
  logic [12:0]            out_pitch_align;
  logic [6:0]             out_height_align;
  logic [31:0]            out_base_align_bytes;
  logic [15:0]            out_aligned_pitch;
  logic [15:0]            out_aligned_height;
  logic [31:0]            out_row_bytes;
  logic [39:0]            out_plane_bytes;
  logic                   out_degrades;
  int                     fail_count;
  int                     pending;
  int                     idle_pct = 0;

  tiled_surface_level_layout_core u_top (.*);
  tsl_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic layout_req_t make_req(input logic [1:0] mode, input int bw, input int bh,
                                           input int lvl, input int esz, input int sl,
                                           input int scan, input int check);
    layout_req_t r;
    r.mode = mode;
    r.bw = bw[EXTENT_BITS-1:0];
    r.bh = bh[EXTENT_BITS-1:0];
    r.lvl = lvl[3:0];
    r.esz = esz[2:0];
    r.sl = sl[1:0];
    r.scan = scan[0];
    r.check = check[0];
    return r;
  endfunction

  function automatic int random_extent();
    case ($urandom_range(3))
      0: return $urandom_range(0, 64);
      1: return $urandom & 32'h7fff;
      default: return $urandom_range(1, 16384);
    endcase
  endfunction

  function automatic layout_req_t random_req();
    return make_req(2'($urandom_range(3)), random_extent(), random_extent(),
                    ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(15),
                    ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(7),
                    $urandom_range(3), $urandom_range(1), $urandom_range(1));
  endfunction

  task automatic send_request(input layout_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_tiling_mode <= r.mode;
    in_base_width <= r.bw;
    in_base_height <= r.bh;
    in_mip_level <= r.lvl;
    in_element_size_log2 <= r.esz;
    in_samples_log2 <= r.sl;
    in_scanout_en <= r.scan;
    in_degrade_check <= r.check;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(input logic [3:0] grp, input logic [1:0] pipes,
                              input logic [1:0] banks);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GROUP_BYTES;
    cfg_wdata <= grp;
    @(posedge clk);
    cfg_index <= CFG_PIPES;
    cfg_wdata <= {2'($urandom_range(3)), pipes};
    @(posedge clk);
    cfg_index <= CFG_BANKS;
    cfg_wdata <= {2'($urandom_range(3)), banks};
    @(posedge clk);
    // unmapped index, must leave every register alone
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 4'($urandom_range(15));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [3:0] grp_sel [PHASES];
    logic [1:0] pipes_sel [PHASES];
    logic [1:0] banks_sel [PHASES];
    int pct_sel [3];
    int drain_at;
    grp_sel = '{4'd8, 4'd12, 4'd15, 4'd0, 4'd10, 4'd9, 4'd11, 4'd7};
    pipes_sel = '{2'd0, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1};
    banks_sel = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd3, 2'd0};
    pct_sel = '{0, 45, 7};
    rst_n <= 1'b0;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_GROUP_BYTES;
    cfg_wdata <= '0;
    in_tiling_mode <= MODE_LINEAR;
    in_base_width <= '0;
    in_base_height <= '0;
    in_mip_level <= '0;
    in_element_size_log2 <= '0;
    in_samples_log2 <= '0;
    in_scanout_en <= 1'b0;
    in_degrade_check <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, back to back
    send_request(make_req(MODE_LINEAR, 16384, 16384, 0, 0, 0, 0, 0));
    send_request(make_req(MODE_1D, 1, 1, 0, 0, 0, 0, 0));
    send_request(make_req(MODE_2D, 1024, 768, 0, 2, 0, 0, 0));
    send_request(make_req(MODE_UNUSED, 500, 300, 0, 1, 2, 1, 0));
    send_request(make_req(MODE_2D, 32767, 32767, 0, 4, 3, 1, 0));
    send_request(make_req(MODE_1D, 0, 0, 0, 1, 1, 0, 0));
    send_request(make_req(MODE_2D, 100, 60, 1, 0, 0, 0, 0));
    send_request(make_req(MODE_LINEAR, 300, 5, 15, 0, 0, 0, 0));
    send_request(make_req(MODE_2D, 16384, 16384, 14, 0, 0, 0, 1));
    send_request(make_req(MODE_2D, 8, 8, 0, 0, 0, 0, 1));
    send_request(make_req(MODE_2D, 4096, 4096, 0, 0, 0, 0, 1));
    send_request(make_req(MODE_1D, 4, 4, 0, 2, 0, 0, 1));
    send_request(make_req(MODE_LINEAR, 64, 1, 0, 0, 0, 0, 1));
    send_request(make_req(MODE_1D, 100, 100, 0, 0, 0, 1, 0));
    send_request(make_req(MODE_2D, 100, 100, 0, 3, 2, 1, 0));
    send_request(make_req(MODE_LINEAR, 77, 33, 3, 7, 0, 1, 0));
    send_request(make_req(MODE_1D, 32767, 1, 0, 5, 3, 0, 0));
    send_request(make_req(MODE_2D, 12345, 321, 2, 6, 1, 1, 1));
    send_request(make_req(MODE_LINEAR, 1, 32767, 0, 4, 3, 0, 0));
    send_request(make_req(MODE_2D, 32767, 32767, 0, 4, 3, 0, 0));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 5) write_config(grp_sel[phase], pipes_sel[phase], banks_sel[phase]);
      else write_config(4'($urandom_range(15)), 2'($urandom_range(3)),
                        2'($urandom_range(3)));
      idle_pct = pct_sel[phase % 3];
      drain_at = $urandom_range(10, PHASE_REQUESTS - 10);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if (i == drain_at) drain();
        send_request(random_req());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tsl_pkg.sv
hw/rtl/tsl_extent.sv
hw/rtl/tsl_align.sv
hw/rtl/tiled_surface_level_layout_core.sv
tb/tsl_checker.sv
tb/tb.sv
